FILE: hw/rtl/ucd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

  // Tile geometry
  localparam int TILE_COLS = 256;
  localparam int TILE_ROWS = 256;
  localparam int COL_W     = $clog2(TILE_COLS);
  localparam int ROW_W     = $clog2(TILE_ROWS);
  localparam int CMP_W     = (ROW_W > COL_W) ? ((ROW_W > 8) ? ROW_W : 8)
                                             : ((COL_W > 8) ? COL_W : 8);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TILE_ROWS - 1);

  // Datapath widths
  localparam int DATA_W  = 32;
  localparam int DIFF_W  = 34;               // up+down-2u needs two extra bits
  localparam int PROD_W  = DATA_W + DIFF_W;
  localparam int TERM_W  = PROD_W - 16;      // product after the Q16 shift
  localparam int ACC_W   = TERM_W + 3;       // u plus four terms
  localparam int OUT_TDATA_W = 80;

  localparam logic signed [DATA_W-1:0] MINUS_ONE_Q16 = 32'shFFFF0000;
  localparam logic signed [ACC_W-1:0]  SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  SAT_MIN = ACC_W'(-64'sd2147483648);

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_ROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD_COL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KC_ROW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KC_COL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LAST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL_FIRST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LAST  = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] kd_row;
    logic signed [DATA_W-1:0] kd_col;
    logic signed [DATA_W-1:0] kc_row;
    logic signed [DATA_W-1:0] kc_col;
    logic [7:0]               row_first;
    logic [7:0]               row_last;
    logic [7:0]               col_first;
    logic [7:0]               col_last;
  } cfg_t;

  // Line buffer read request
  typedef struct packed {
    logic                     en;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] din;
  } lb_req_t;

  // Line buffer response, in the cycle after the request
  typedef struct packed {
    logic                     valid;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] mid;
    logic signed [DATA_W-1:0] din;
  } lb_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] running_max;
    logic                     tile_done;
    logic [7:0]               out_col;
    logic [7:0]               out_row;
    logic signed [DATA_W-1:0] new_value;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ucd_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

// Two line buffers held as one memory: each entry is {older, middle}.
// Read on accept; the next cycle writes {middle, cell} back to that entry.
// The next read of that entry is a full row away, so no forwarding is needed.
module ucd_line_buf import ucd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  lb_req_t req_i,
  output lb_rsp_t rsp_o
);

  logic [2*DATA_W-1:0]      mem [TILE_COLS];
  logic [2*DATA_W-1:0]      rdata_q;
  logic                     valid_q;
  logic [ROW_W-1:0]         row_q;
  logic [COL_W-1:0]         col_q;
  logic signed [DATA_W-1:0] cell_q;

  // memory read and write-back
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      rdata_q <= mem[req_i.col];
    end
    if (valid_q) begin
      mem[col_q] <= {rdata_q[DATA_W-1:0], cell_q};
    end
  end

  // request tag
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      row_q  <= req_i.row;
      col_q  <= req_i.col;
      cell_q <= req_i.din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.en;
    end
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.row   = row_q;
  assign rsp_o.col   = col_q;
  assign rsp_o.top   = rdata_q[2*DATA_W-1:DATA_W];
  assign rsp_o.mid   = rdata_q[DATA_W-1:0];
  assign rsp_o.din   = cell_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ucd_stencil.sv
`timescale 1ns / 1ps
`default_nettype none

// Window registers, difference stage, multiply stage, sum/saturate stage
// and the per-tile running maximum.
module ucd_stencil import ucd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  lb_rsp_t    rsp_i,
  output logic [1:0] pend_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  // window: up, left, center, down
  logic signed [DATA_W-1:0] w_up_q, w_left_q, w_ctr_q, w_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_up_q   <= '0;
      w_left_q <= '0;
      w_ctr_q  <= '0;
      w_down_q <= '0;
    end else if (rsp_i.valid) begin
      w_up_q   <= rsp_i.top;
      w_left_q <= w_ctr_q;
      w_ctr_q  <= rsp_i.mid;
      w_down_q <= rsp_i.din;
    end
  end

  // ---- stage 2: differences
  logic                     emit;
  logic [ROW_W-1:0]         orow;
  logic [COL_W-1:0]         ocol;
  logic                     conv_en;
  logic signed [DIFF_W-1:0] up_x, left_x, ctr_x, down_x, right_x;
  logic signed [DIFF_W-1:0] dv_d, dh_d, dr_d, dc_d;

  always_comb begin
    emit    = rsp_i.valid && (rsp_i.row >= ROW_W'(2)) && (rsp_i.col >= COL_W'(2));
    orow    = rsp_i.row - ROW_W'(1);
    ocol    = rsp_i.col - COL_W'(1);
    conv_en = (CMP_W'(orow) >= CMP_W'(cfg_i.row_first)) &&
              (CMP_W'(orow) <= CMP_W'(cfg_i.row_last))  &&
              (CMP_W'(ocol) >= CMP_W'(cfg_i.col_first)) &&
              (CMP_W'(ocol) <= CMP_W'(cfg_i.col_last));
    up_x    = DIFF_W'(w_up_q);
    left_x  = DIFF_W'(w_left_q);
    ctr_x   = DIFF_W'(w_ctr_q);
    down_x  = DIFF_W'(w_down_q);
    right_x = DIFF_W'(rsp_i.mid);
    dv_d    = up_x + down_x - (ctr_x <<< 1);
    dh_d    = left_x + right_x - (ctr_x <<< 1);
    // upwind direction follows the coefficient sign
    dr_d    = (cfg_i.kc_row > 0) ? (ctr_x - up_x) : (down_x - ctr_x);
    dc_d    = (cfg_i.kc_col > 0) ? (ctr_x - left_x) : (right_x - ctr_x);
    if (!conv_en) begin
      dr_d = '0;
      dc_d = '0;
    end
  end

  logic                     s2_valid_q;
  logic signed [DATA_W-1:0] s2_u_q;
  logic signed [DIFF_W-1:0] s2_dv_q, s2_dh_q, s2_dr_q, s2_dc_q;
  logic [7:0]               s2_row_q, s2_col_q;
  logic                     s2_last_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s2_u_q    <= w_ctr_q;
      s2_dv_q   <= dv_d;
      s2_dh_q   <= dh_d;
      s2_dr_q   <= dr_d;
      s2_dc_q   <= dc_d;
      s2_row_q  <= 8'(orow);
      s2_col_q  <= 8'(ocol);
      s2_last_q <= (rsp_i.row == ROW_LAST) && (rsp_i.col == COL_LAST);
    end
  end

  // ---- stage 3: coefficient products, floor shift by 16
  logic signed [PROD_W-1:0] p_dv, p_dh, p_dr, p_dc;

  assign p_dv = PROD_W'(cfg_i.kd_row) * PROD_W'(s2_dv_q);
  assign p_dh = PROD_W'(cfg_i.kd_col) * PROD_W'(s2_dh_q);
  assign p_dr = PROD_W'(cfg_i.kc_row) * PROD_W'(s2_dr_q);
  assign p_dc = PROD_W'(cfg_i.kc_col) * PROD_W'(s2_dc_q);

  logic                     s3_valid_q;
  logic signed [DATA_W-1:0] s3_u_q;
  logic signed [TERM_W-1:0] s3_dv_q, s3_dh_q, s3_dr_q, s3_dc_q;
  logic [7:0]               s3_row_q, s3_col_q;
  logic                     s3_last_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_u_q    <= s2_u_q;
      s3_dv_q   <= p_dv[PROD_W-1:16];
      s3_dh_q   <= p_dh[PROD_W-1:16];
      s3_dr_q   <= p_dr[PROD_W-1:16];
      s3_dc_q   <= p_dc[PROD_W-1:16];
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
    end
  end

  // ---- stage 4: sum and saturate
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] sat;

  always_comb begin
    acc = ACC_W'(s3_u_q) + ACC_W'(s3_dv_q) + ACC_W'(s3_dh_q)
        - ACC_W'(s3_dr_q) - ACC_W'(s3_dc_q);
    if (acc > SAT_MAX) begin
      sat = SAT_MAX[DATA_W-1:0];
    end else if (acc < SAT_MIN) begin
      sat = SAT_MIN[DATA_W-1:0];
    end else begin
      sat = acc[DATA_W-1:0];
    end
  end

  logic                     s4_valid_q;
  logic signed [DATA_W-1:0] s4_val_q;
  logic [7:0]               s4_row_q, s4_col_q;
  logic                     s4_last_q;

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      s4_val_q  <= sat;
      s4_row_q  <= s3_row_q;
      s4_col_q  <= s3_col_q;
      s4_last_q <= s3_last_q;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= emit;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // ---- running maximum, back to -1.0 after the last cell of a tile
  logic signed [DATA_W-1:0] tile_max_q, tile_max_d, run_max;

  always_comb begin
    run_max    = (s4_val_q > tile_max_q) ? s4_val_q : tile_max_q;
    tile_max_d = tile_max_q;
    if (s4_valid_q) begin
      tile_max_d = s4_last_q ? MINUS_ONE_Q16 : run_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_max_q <= MINUS_ONE_Q16;
    end else begin
      tile_max_q <= tile_max_d;
    end
  end

  assign pend_o      = 2'(s2_valid_q) + 2'(s3_valid_q) + 2'(s4_valid_q);
  assign res_valid_o = s4_valid_q;
  assign res_o.new_value   = s4_val_q;
  assign res_o.out_row     = s4_row_q;
  assign res_o.out_col     = s4_col_q;
  assign res_o.tile_done   = s4_last_q;
  assign res_o.running_max = run_max;

endmodule

`default_nettype wire

FILE: hw/rtl/ucd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Small result queue between the pipeline and the output stream.
module ucd_out_fifo import ucd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output result_t               data_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t                 buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/upwind_convection_diffusion_stencil.sv
`timescale 1ns / 1ps
`default_nettype none

// One explicit Euler step of upwind convection-diffusion on a raster stream
// of Q16.16 cells. The block takes one cell per clock while tready is high;
// each cell is read from and written back to a line-buffer memory (one read
// and one write port), and the update of the interior cell one row up and
// one column left passes the read, difference, product and sum registers
// and an eight-entry output queue. tready falls only when that queue plus
// the four pipeline stages would hold more than eight transactions, so a
// stalled consumer causes no loss. Border cells give no output; tlast marks
// the last interior cell of a tile, and the running maximum restarts at
// -1.0 with each tile. The user must write coefficient and window registers
// only while no transaction is in flight; the block does not enforce it.
module upwind_convection_diffusion_stencil import ucd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_W-1:0]      cfg_wdata_i,
  // cell stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] cell_value
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] new_value, [39:32] out_row,
                                                 // [47:40] out_col, [79:48] running_max
  output logic                   m_axis_tlast    // tile_done
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kd_row    <= '0;
      cfg_q.kd_col    <= '0;
      cfg_q.kc_row    <= '0;
      cfg_q.kc_col    <= '0;
      cfg_q.row_first <= 8'd1;
      cfg_q.row_last  <= 8'd254;
      cfg_q.col_first <= 8'd1;
      cfg_q.col_last  <= 8'd254;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KD_ROW:    cfg_q.kd_row    <= cfg_wdata_i;
        REG_KD_COL:    cfg_q.kd_col    <= cfg_wdata_i;
        REG_KC_ROW:    cfg_q.kc_row    <= cfg_wdata_i;
        REG_KC_COL:    cfg_q.kc_col    <= cfg_wdata_i;
        REG_ROW_FIRST: cfg_q.row_first <= cfg_wdata_i[7:0];
        REG_ROW_LAST:  cfg_q.row_last  <= cfg_wdata_i[7:0];
        REG_COL_FIRST: cfg_q.col_first <= cfg_wdata_i[7:0];
        REG_COL_LAST:  cfg_q.col_last  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // raster position
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_fire) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line buffers
  lb_req_t lb_req;
  lb_rsp_t lb_rsp;

  assign lb_req.en   = in_fire;
  assign lb_req.row  = row_q;
  assign lb_req.col  = col_q;
  assign lb_req.din  = s_axis_tdata;

  ucd_line_buf u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lb_req),
    .rsp_o  (lb_rsp)
  );

  // arithmetic pipeline
  logic       res_valid;
  result_t    res;
  logic [1:0] pend;

  ucd_stencil u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rsp_i       (lb_rsp),
    .pend_o      (pend),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output queue
  logic                  out_pop;
  result_t               head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  assign out_pop = m_axis_tvalid && m_axis_tready;

  ucd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (out_pop),
    .valid_o (m_axis_tvalid),
    .data_o  (head),
    .count_o (fifo_cnt)
  );

  // credit check: queue entries plus everything still in the pipeline
  logic [FIFO_CNT_W+1:0] occupancy;

  assign occupancy = (FIFO_CNT_W+2)'(fifo_cnt) + (FIFO_CNT_W+2)'(pend)
                   + (FIFO_CNT_W+2)'(lb_rsp.valid);
  assign s_axis_tready = (occupancy < (FIFO_CNT_W+2)'(FIFO_DEPTH));

  assign m_axis_tdata = {head.running_max, head.out_col, head.out_row, head.new_value};
  assign m_axis_tlast = head.tile_done;

`ifndef SYNTHESIS
  // a result never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // end of tile only on the last interior cell
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      ((head.out_row == 8'(TILE_ROWS - 2)) && (head.out_col == 8'(TILE_COLS - 2))))
    else $error("tile_done at wrong position");

  // reported maximum covers the value it travels with
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (head.running_max >= head.new_value))
    else $error("running maximum below new value");

  // column counter stays inside the tile
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (col_q <= COL_LAST))
    else $error("column counter out of range");
`endif

endmodule

`default_nettype wire

FILE: test/upwind_convection_diffusion_stencil_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the stencil: shadows the registers, line buffers and window,
// predicts each updated cell and compares it with the result stream.
module upwind_convection_diffusion_stencil_checker import ucd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_W-1:0]      cfg_wdata_i,
  input  logic                   cell_valid_i,
  input  logic                   cell_ready_i,
  input  logic [DATA_W-1:0]      cell_data_i,
  input  logic                   result_valid_i,
  input  logic                   result_ready_i,
  input  logic [OUT_TDATA_W-1:0] result_data_i,
  input  logic                   result_last_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  // Shadow of the coefficient and window registers
  logic signed [DATA_W-1:0] kd_row, kd_col, kc_row, kc_col;
  logic [7:0]               row_first, row_last, col_first, col_last;

  // Shadow of the line buffers, the window and the raster position
  logic signed [DATA_W-1:0] prev_line [TILE_COLS];
  logic signed [DATA_W-1:0] cur_line  [TILE_COLS];
  logic signed [DATA_W-1:0] win [6];
  int                       row_pos, col_pos;
  logic signed [DATA_W-1:0] tile_peak;

  result_t expected_updates [$];
  int      fail_count = 0;

  // floor(coef * diff / 2^16), exact
  function automatic logic signed [71:0] scale_q16(input logic signed [31:0] coef,
                                                   input logic signed [35:0] diff);
    logic signed [71:0] a, b;
    a = coef;
    b = diff;
    return (a * b) >>> 16;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  // One raster cell: update shadow state, queue the updated interior cell if any
  task automatic stencil_step(input logic signed [31:0] cell_in);
    logic signed [31:0] top_in, mid_in, nv;
    logic signed [35:0] e_up, e_left, e_ctr, e_down, e_right, d_row, d_col;
    logic signed [71:0] acc;
    result_t            upd;
    int                 orow, ocol;
    top_in = prev_line[col_pos];
    mid_in = cur_line[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      e_up    = win[1];
      e_left  = win[2];
      e_ctr   = win[3];
      e_down  = win[5];
      e_right = mid_in;
      orow = row_pos - 1;
      ocol = col_pos - 1;
      acc = e_ctr;
      acc = acc + scale_q16(kd_row, e_up + e_down - (e_ctr <<< 1));
      acc = acc + scale_q16(kd_col, e_left + e_right - (e_ctr <<< 1));
      // upwind convection, only inside the row and column windows
      if (orow >= row_first && orow <= row_last && ocol >= col_first && ocol <= col_last) begin
        d_row = (kc_row > 0) ? (e_ctr - e_up) : (e_down - e_ctr);
        d_col = (kc_col > 0) ? (e_ctr - e_left) : (e_right - e_ctr);
        acc = acc - scale_q16(kc_row, d_row) - scale_q16(kc_col, d_col);
      end
      if (acc > SAT_HI) nv = 32'sh7FFFFFFF;
      else if (acc < SAT_LO) nv = 32'sh80000000;
      else nv = acc[31:0];
      if (nv > tile_peak) tile_peak = nv;
      upd.new_value   = nv;
      upd.out_row     = 8'(orow);
      upd.out_col     = 8'(ocol);
      upd.tile_done   = (orow == TILE_ROWS - 2) && (ocol == TILE_COLS - 2);
      upd.running_max = tile_peak;
      expected_updates.push_back(upd);
    end
    win[0] = win[1];
    win[1] = top_in;
    win[2] = win[3];
    win[3] = mid_in;
    win[4] = win[5];
    win[5] = cell_in;
    prev_line[col_pos] = cur_line[col_pos];
    cur_line[col_pos]  = cell_in;
    // raster advance, wrap at the end of the tile
    if (col_pos + 1 >= TILE_COLS) begin
      col_pos = 0;
      if (row_pos + 1 >= TILE_ROWS) begin
        row_pos   = 0;
        tile_peak = MINUS_ONE_Q16;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      kd_row    = '0;
      kd_col    = '0;
      kc_row    = '0;
      kc_col    = '0;
      row_first = 8'd1;
      row_last  = 8'd254;
      col_first = 8'd1;
      col_last  = 8'd254;
      for (int i = 0; i < TILE_COLS; i++) begin
        prev_line[i] = '0;
        cur_line[i]  = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      row_pos   = 0;
      col_pos   = 0;
      tile_peak = MINUS_ONE_Q16;
      expected_updates.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KD_ROW:    kd_row    = cfg_wdata_i;
          REG_KD_COL:    kd_col    = cfg_wdata_i;
          REG_KC_ROW:    kc_row    = cfg_wdata_i;
          REG_KC_COL:    kc_col    = cfg_wdata_i;
          REG_ROW_FIRST: row_first = cfg_wdata_i[7:0];
          REG_ROW_LAST:  row_last  = cfg_wdata_i[7:0];
          REG_COL_FIRST: col_first = cfg_wdata_i[7:0];
          REG_COL_LAST:  col_last  = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      // accepted cell transaction
      if (cell_valid_i && cell_ready_i) stencil_step(cell_data_i);
      // accepted result transaction
      if (result_valid_i && result_ready_i) begin
        if (expected_updates.size() == 0) begin
          fail_count++;
          $error("result transaction with no update pending: data %0h", result_data_i);
        end else begin
          want = expected_updates.pop_front();
          check_field("new_value", want.new_value, result_data_i[31:0]);
          check_field("out_row", 32'(want.out_row), 32'(result_data_i[39:32]));
          check_field("out_col", 32'(want.out_col), 32'(result_data_i[47:40]));
          check_field("tile_done", 32'(want.tile_done), 32'(result_last_i));
          check_field("running_max", want.running_max, result_data_i[79:48]);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_updates.size();
  end

endmodule

FILE: test/upwind_convection_diffusion_stencil_tb.sv
`timescale 1ns / 1ps

module upwind_convection_diffusion_stencil_tb;
  import ucd_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 16;

  typedef enum {FILL_MIXED, FILL_NEGATIVE} fill_e;
  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_PULSED} ready_mode_e;

  // Extremes and bit patterns, fed at the start of rows 1 and 2 of the tile
  localparam logic [31:0] CORNER_VALUES [24] = '{
    32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF, 32'h00010000, 32'hFFFF0000,
    32'h00000001, 32'h55555555, 32'hAAAAAAAA, 32'h7FFF0000, 32'h80010000, 32'h0000FFFF,
    32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
    32'h80000000, 32'h80000000, 32'h00008000, 32'hFFFF8000, 32'h12345678, 32'hEDCBA988
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [DATA_W-1:0]      cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  int                     fail_count;
  int                     pending;
  int                     cells_sent = 0;

  always #4 clk = ~clk;

  upwind_convection_diffusion_stencil u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  upwind_convection_diffusion_stencil_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .cell_valid_i   (s_axis_tvalid),
    .cell_ready_i   (s_axis_tready),
    .cell_data_i    (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .result_last_i  (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result-side backpressure: phases of steady, random and pulsed readiness
  ready_mode_e ready_mode = RDY_ALWAYS;
  int          ready_left = 0;
  int          ready_tick = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(50, 400);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      default:    m_axis_tready <= ((ready_tick % 24) >= 18);
    endcase
  end

  // Watchdog on cycles with no transaction on either stream
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] random_cell(input fill_e fill);
    logic [31:0] v;
    if (fill == FILL_NEGATIVE && $urandom_range(0, 63) != 0)
      return -$urandom_range(32'h0001_0000, 32'h0040_0000);
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          3: v = 32'hFFFFFFFF;
          4: v = 32'h00010000;
          default: v = 32'hFFFF0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
    return v;
  endfunction

  // Coefficient within +-1.0 mostly, sometimes any 32-bit value
  function automatic logic [31:0] random_coef();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Window bound in the low byte, junk above it
  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] bound);
    write_reg(idx, {24'($urandom), bound});
  endtask

  task automatic write_coefs(input logic [31:0] kdr, input logic [31:0] kdc,
                             input logic [31:0] kcr, input logic [31:0] kcc);
    write_reg(REG_KD_ROW, kdr);
    write_reg(REG_KD_COL, kdc);
    write_reg(REG_KC_ROW, kcr);
    write_reg(REG_KC_COL, kcc);
  endtask

  task automatic write_windows(input logic [7:0] rf, input logic [7:0] rl,
                               input logic [7:0] cf, input logic [7:0] cl);
    write_bound(REG_ROW_FIRST, rf);
    write_bound(REG_ROW_LAST, rl);
    write_bound(REG_COL_FIRST, cf);
    write_bound(REG_COL_LAST, cl);
  endtask

  // Present one cell and hold it until the transaction completes
  task automatic send_cell(input logic [31:0] v);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // The next cells of the raster, in bursts with random gaps
  task automatic stream_cells(input int count, input fill_e fill, input bit with_corners);
    int          burst_left;
    int          gap;
    int          r, c;
    logic [31:0] v;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 800)
                                                 : $urandom_range(1, 64);
      end
      burst_left--;
      r = (cells_sent / TILE_COLS) % TILE_ROWS;
      c = cells_sent % TILE_COLS;
      if (with_corners && r >= 1 && r <= 2 && c < 12) v = CORNER_VALUES[c + 12 * (r - 1)];
      else v = random_cell(fill);
      send_cell(v);
      cells_sent++;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold the sender until every update is out and the pipeline has drained
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] lo, hi;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no coefficients, output follows the center cell
    stream_cells(530, FILL_MIXED, 1'b1);
    settle();

    // Moderate positive coefficients, backward differences, full row window
    write_coefs(32'h0000_4000, 32'h0000_2000, 32'h0000_1000, 32'h0000_0800);
    write_windows(8'd0, 8'd255, 8'd3, 8'd200);
    stream_cells(18, FILL_NEGATIVE, 1'b0);
    settle();

    // Extreme coefficients, mixed difference directions
    write_coefs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    write_windows(8'd0, 8'd255, 8'd0, 8'd255);
    stream_cells(18, FILL_MIXED, 1'b0);
    settle();

    // Random coefficients and random nonempty windows
    write_coefs(random_coef(), random_coef(), random_coef(), random_coef());
    lo = 8'($urandom_range(0, 127));
    hi = 8'($urandom_range(128, 255));
    write_windows(lo, hi, 8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
    stream_cells(17, FILL_MIXED, 1'b0);
    settle();

    // Empty row window switches convection off everywhere
    write_coefs(random_coef(), random_coef(), random_coef(), random_coef());
    write_windows(8'($urandom_range(129, 255)), 8'($urandom_range(0, 128)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    stream_cells(17, FILL_MIXED, 1'b0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
